FILE: rtl/pso_pkg.sv
// shared types, widths and constants of the particle update block
package pso_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned FracW      = 16;
  localparam int unsigned RandW      = 16;
  localparam int unsigned MomW       = 18;
  localparam int unsigned GainW      = 19;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned DimW       = 4;
  localparam int unsigned DimExtW    = 9;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 19;
  localparam int unsigned DefaultDims = 16;

  localparam logic [MomW-1:0]  MomentumRst    = MomW'(58982);
  localparam logic [GainW-1:0] LocalWeightRst  = GainW'(45875);
  localparam logic [GainW-1:0] GlobalWeightRst = GainW'(32768);
  localparam logic [DataW-1:0] BestValueRst   = 32'h7FFF_FFFF;

  typedef enum logic [CmdW-1:0] {
    CMD_INIT   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_VALUE  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOMENTUM = 2'd0,
    CFG_LOCAL    = 2'd1,
    CFG_GLOBAL   = 2'd2
  } cfg_idx_e;

  // one word of the dimension store
  typedef struct packed {
    logic [DataW-1:0] pos;
    logic [DataW-1:0] vel;
    logic [DataW-1:0] best;
    logic [DataW-1:0] lower;
    logic [DataW-1:0] upper;
  } entry_t;

  // stage enables from the sequencer to the datapath
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic is_init;
  } dp_ctrl_t;

  // registered datapath results
  typedef struct packed {
    logic [DataW-1:0] pos;
    logic [DataW-1:0] lower;
    logic [DataW-1:0] upper;
    logic [DataW-1:0] best;
    logic [DataW-1:0] res_pos;
    logic [DataW-1:0] res_vel;
  } dp_res_t;

endpackage

FILE: rtl/pso_particle_update.sv
// top level of the particle update block: sequencer, store, config and result register
//
// one particle of a particle swarm optimizer in q16.16 fixed point. each dimension
// keeps position, velocity, personal best position and its search bounds in one
// dimension store with a registered read; one word moves per handshake on each side.
// an init word seeds a dimension from its bounds and two randoms, an update word
// applies inertia, local and global pulls, clamps to the bounds and writes back, a
// value word keeps the lower objective as the personal best. words are taken one at
// a time: an update passes the store read, the two chained multiplier stages, the
// wide sum and the clamp and write-back before the next word can be taken, an init
// skips the wide sum, a value or no-op word goes straight to the result. the result
// register frees the input side, so the next word can be taken while a result waits.
// there is no clearing pass after reset; entries are defined once initialized.
module pso_particle_update #(
  parameter int unsigned DIMS = pso_pkg::DefaultDims
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [pso_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pso_pkg::CfgDataW-1:0]  cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pso_pkg::CmdW-1:0]      command_i,
  input  logic [pso_pkg::DimW-1:0]      dim_index_i,
  input  logic signed [pso_pkg::DataW-1:0] lower_bound_i,
  input  logic signed [pso_pkg::DataW-1:0] upper_bound_i,
  input  logic signed [pso_pkg::DataW-1:0] swarm_best_i,
  input  logic [pso_pkg::RandW-1:0]     rand_a_i,
  input  logic [pso_pkg::RandW-1:0]     rand_b_i,
  input  logic signed [pso_pkg::DataW-1:0] objective_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [pso_pkg::DataW-1:0] position_out_o,
  output logic signed [pso_pkg::DataW-1:0] velocity_out_o,
  output logic signed [pso_pkg::DataW-1:0] best_value_out_o,
  output logic                          improved_o
);

  localparam int unsigned DW = pso_pkg::DataW;
  localparam int unsigned AW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int unsigned EW = $bits(pso_pkg::entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CROSS,
    ST_SUM,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [pso_pkg::MomW-1:0]  momentum_q;
  logic [pso_pkg::GainW-1:0] local_weight_q;
  logic [pso_pkg::GainW-1:0] global_weight_q;

  // captured word
  pso_pkg::cmd_e             cmd_q;
  logic [AW-1:0]             addr_q;
  logic                      in_range_q;
  logic [DW-1:0]             lb_q, ub_q, gb_q, obj_q;
  logic [pso_pkg::RandW-1:0] ra_q, rb_q;

  // particle-wide state
  logic [DW-1:0]   best_value_q;
  logic [DIMS-1:0] linked_q;   // best position equals current position
  logic            out_valid_q;
  logic [DW-1:0]   out_pos_q, out_vel_q, out_best_q;
  logic            out_imp_q;

  logic [pso_pkg::DimExtW-1:0] dim_ext;
  logic                        in_range;
  logic                        accept;
  logic                        out_free;
  logic                        is_write;
  logic                        improve;
  logic                        link_bit;

  pso_pkg::entry_t   rd_entry, wr_entry;
  logic [EW-1:0]     rd_word;
  pso_pkg::dp_ctrl_t dp_ctrl;
  pso_pkg::dp_res_t  dp_res;

  // clamp of the updated position
  logic signed [DW:0] pos_sum, lo_x, up_x, pos_a;
  logic               lo_hit, up_hit;
  logic [DW-1:0]      upd_pos, upd_vel, fin_pos, fin_vel;

  assign dim_ext    = pso_pkg::DimExtW'(dim_index_i);
  assign in_range   = dim_ext < pso_pkg::DimExtW'(DIMS);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      momentum_q      <= pso_pkg::MomentumRst;
      local_weight_q  <= pso_pkg::LocalWeightRst;
      global_weight_q <= pso_pkg::GlobalWeightRst;
    end else if (cfg_we_i) begin
      unique case (pso_pkg::cfg_idx_e'(cfg_index_i))
        pso_pkg::CFG_MOMENTUM: momentum_q      <= cfg_data_i[pso_pkg::MomW-1:0];
        pso_pkg::CFG_LOCAL:    local_weight_q  <= cfg_data_i;
        pso_pkg::CFG_GLOBAL:   global_weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dimension store, read at acceptance, written back when the result is issued
  pso_ram #(
    .WIDTH (EW),
    .DEPTH (DIMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (is_write),
    .waddr_i (addr_q),
    .wdata_i (wr_entry),
    .re_i    (accept),
    .raddr_i (dim_ext[AW-1:0]),
    .rdata_o (rd_word)
  );

  assign rd_entry = pso_pkg::entry_t'(rd_word);
  assign link_bit = linked_q[addr_q];

  assign dp_ctrl.s1_en   = (state_q == ST_MUL);
  assign dp_ctrl.s2_en   = (state_q == ST_CROSS);
  assign dp_ctrl.s3_en   = (state_q == ST_SUM);
  assign dp_ctrl.is_init = (cmd_q == pso_pkg::CMD_INIT);

  pso_dp u_dp (
    .clk_i           (clk_i),
    .ctrl_i          (dp_ctrl),
    .entry_i         (rd_entry),
    .link_i          (link_bit),
    .lb_i            (lb_q),
    .ub_i            (ub_q),
    .gb_i            (gb_q),
    .ra_i            (ra_q),
    .rb_i            (rb_q),
    .momentum_i      (momentum_q),
    .local_weight_i  (local_weight_q),
    .global_weight_i (global_weight_q),
    .res_o           (dp_res)
  );

  // new position, lower bound checked first so the upper bound wins when they cross
  always_comb begin
    pos_sum = $signed({dp_res.pos[DW-1], dp_res.pos})
            + $signed({dp_res.res_vel[DW-1], dp_res.res_vel});
    lo_x    = {dp_res.lower[DW-1], dp_res.lower};
    up_x    = {dp_res.upper[DW-1], dp_res.upper};
    lo_hit  = pos_sum < lo_x;
    pos_a   = lo_hit ? lo_x : pos_sum;
    up_hit  = pos_a > up_x;
    upd_pos = up_hit ? dp_res.upper : pos_a[DW-1:0];
    upd_vel = (lo_hit || up_hit) ? '0 : dp_res.res_vel;
  end

  always_comb begin
    fin_pos  = '0;
    fin_vel  = '0;
    wr_entry = '0;
    case (cmd_q)
      pso_pkg::CMD_INIT: begin
        fin_pos        = dp_res.res_pos;
        fin_vel        = dp_res.res_vel;
        wr_entry.pos   = dp_res.res_pos;
        wr_entry.vel   = dp_res.res_vel;
        wr_entry.best  = dp_res.res_pos;
        wr_entry.lower = lb_q;
        wr_entry.upper = ub_q;
      end
      pso_pkg::CMD_UPDATE: begin
        fin_pos        = upd_pos;
        fin_vel        = upd_vel;
        wr_entry.pos   = upd_pos;
        wr_entry.vel   = upd_vel;
        wr_entry.best  = dp_res.best;
        wr_entry.lower = dp_res.lower;
        wr_entry.upper = dp_res.upper;
      end
      default: ;
    endcase
    if (!in_range_q) begin
      fin_pos = '0;
      fin_vel = '0;
    end
  end

  assign is_write = (state_q == ST_DONE) && out_free && in_range_q
                 && ((cmd_q == pso_pkg::CMD_INIT) || (cmd_q == pso_pkg::CMD_UPDATE));
  assign improve  = (cmd_q == pso_pkg::CMD_VALUE) && ($signed(obj_q) < $signed(best_value_q));

  // sequencer with the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      best_value_q <= pso_pkg::BestValueRst;
      linked_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q      <= pso_pkg::cmd_e'(command_i);
            addr_q     <= dim_ext[AW-1:0];
            in_range_q <= in_range;
            lb_q       <= lower_bound_i;
            ub_q       <= upper_bound_i;
            gb_q       <= swarm_best_i;
            ra_q       <= rand_a_i;
            rb_q       <= rand_b_i;
            obj_q      <= objective_i;
            if (in_range && ((command_i == pso_pkg::CMD_INIT)
                          || (command_i == pso_pkg::CMD_UPDATE))) begin
              state_q <= ST_MUL;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_MUL:   state_q <= ST_CROSS;
        ST_CROSS: state_q <= (cmd_q == pso_pkg::CMD_INIT) ? ST_DONE : ST_SUM;
        ST_SUM:   state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        out_pos_q   <= fin_pos;
        out_vel_q   <= fin_vel;
        out_best_q  <= improve ? obj_q : best_value_q;
        out_imp_q   <= improve;
        if (improve) begin
          best_value_q <= obj_q;
          linked_q     <= '1;  // every best position now tracks its position
        end
        if (is_write) begin
          linked_q[addr_q] <= 1'b0;  // best position was stored explicitly
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_out_o   = out_pos_q;
  assign velocity_out_o   = out_vel_q;
  assign best_value_out_o = out_best_q;
  assign improved_o       = out_imp_q;

endmodule

FILE: rtl/pso_ram.sv
// generic single-port-write, registered-read memory
module pso_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pso_dp.sv
// arithmetic stages of the particle update: products, cross products, sum
module pso_dp (
  input  logic                         clk_i,
  input  pso_pkg::dp_ctrl_t            ctrl_i,
  input  pso_pkg::entry_t              entry_i,
  input  logic                         link_i,
  input  logic [pso_pkg::DataW-1:0]    lb_i,
  input  logic [pso_pkg::DataW-1:0]    ub_i,
  input  logic [pso_pkg::DataW-1:0]    gb_i,
  input  logic [pso_pkg::RandW-1:0]    ra_i,
  input  logic [pso_pkg::RandW-1:0]    rb_i,
  input  logic [pso_pkg::MomW-1:0]     momentum_i,
  input  logic [pso_pkg::GainW-1:0]    local_weight_i,
  input  logic [pso_pkg::GainW-1:0]    global_weight_i,
  output pso_pkg::dp_res_t             res_o
);

  localparam int unsigned DW   = pso_pkg::DataW;
  localparam int unsigned FW   = pso_pkg::FracW;
  localparam int unsigned RW   = pso_pkg::RandW;
  localparam int unsigned GW   = pso_pkg::GainW;
  localparam int unsigned MW   = pso_pkg::MomW;
  localparam int unsigned OpAW = DW + 1;
  localparam int unsigned OpCW = DW + 2;
  localparam int unsigned OpBW = GW;
  localparam int unsigned P01W = OpAW + OpBW;
  localparam int unsigned P2W  = OpCW + OpBW;
  localparam int unsigned TW   = (GW + 1) + (DW + 1);
  localparam int unsigned SumW = TW + 2;
  localparam int unsigned RndW = SumW - FW;
  localparam int unsigned One  = 1 << FW;
  localparam int unsigned Half = 1 << (FW - 1);

  function automatic logic [DW-1:0] sat32(input logic [RndW-1:0] x);
    logic hi_same;
    logic lo_same;
    hi_same = &x[RndW-1:DW-1];
    lo_same = ~|x[RndW-1:DW-1];
    if (hi_same || lo_same) begin
      return x[DW-1:0];
    end else if (x[RndW-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  // stage 1 operands
  logic [DW-1:0]          p, v, bpe;
  logic signed [DW:0]     lb_x, ub_x, del_s;
  logic [DW:0]            del;
  logic [RW:0]            ra_c;
  logic signed [RW+1:0]   rb_c;
  logic signed [OpAW-1:0] a0, a1;
  logic signed [OpCW-1:0] a2;
  logic signed [OpBW-1:0] b0, b1, b2;
  logic signed [P01W-1:0] prod0_d, prod1_d;
  logic signed [P2W-1:0]  prod2_d;
  logic signed [DW:0]     diffl_d, diffg_d;

  logic signed [P01W-1:0] prod0_q, prod1_q;
  logic signed [P2W-1:0]  prod2_q;
  logic signed [DW:0]     diffl_q, diffg_q;
  logic [DW-1:0]          p_q, lo_q, up_q, bp_q;

  // stage 2
  logic [P01W-1:0]        rl_sum;
  logic [P2W-1:0]         rg_sum, iv_sum, ip_sum;
  logic signed [GW:0]     gl, gg;
  logic signed [TW-1:0]   t1_d, t2_d, t1_q, t2_q;
  logic signed [P01W-1:0] wv_q;
  logic [DW-1:0]          res_pos_q, res_vel_q;

  // stage 3
  logic [SumW-1:0]        usum;

  always_comb begin
    p     = entry_i.pos;
    v     = entry_i.vel;
    bpe   = link_i ? entry_i.pos : entry_i.best;
    lb_x  = {lb_i[DW-1], lb_i};
    ub_x  = {ub_i[DW-1], ub_i};
    del_s = lb_x - ub_x;
    del   = del_s[DW] ? (~del_s + 1'b1) : del_s;
    ra_c  = (RW+1)'(One) - {1'b0, ra_i};
    rb_c  = (RW+2)'(One) - {1'b0, rb_i, 1'b0};
    if (ctrl_i.is_init) begin
      a0 = {lb_i[DW-1], lb_i};
      b0 = OpBW'({1'b0, ra_i});
      a1 = {ub_i[DW-1], ub_i};
      b1 = OpBW'({1'b0, ra_c});
      a2 = {1'b0, del};
      b2 = {{(OpBW-RW-2){rb_c[RW+1]}}, rb_c};
    end else begin
      a0 = {v[DW-1], v};
      b0 = OpBW'({1'b0, momentum_i});
      a1 = OpAW'(local_weight_i);
      b1 = OpBW'(ra_i);
      a2 = OpCW'(global_weight_i);
      b2 = OpBW'(rb_i);
    end
    prod0_d = a0 * b0;
    prod1_d = a1 * b1;
    prod2_d = a2 * b2;
    diffl_d = $signed({bpe[DW-1], bpe}) - $signed({p[DW-1], p});
    diffg_d = $signed({gb_i[DW-1], gb_i}) - $signed({p[DW-1], p});
  end

  always_comb begin
    rl_sum = prod1_q + P01W'(Half);
    rg_sum = prod2_q + P2W'(Half);
    gl     = {1'b0, rl_sum[FW +: GW]};
    gg     = {1'b0, rg_sum[FW +: GW]};
    t1_d   = gl * diffl_q;
    t2_d   = gg * diffg_q;
    ip_sum = {prod0_q[P01W-1], prod0_q} + {prod1_q[P01W-1], prod1_q} + P2W'(Half);
    iv_sum = prod2_q + P2W'(Half);
    usum   = {{(SumW-P01W){wv_q[P01W-1]}}, wv_q}
           + {{(SumW-TW){t1_q[TW-1]}}, t1_q}
           + {{(SumW-TW){t2_q[TW-1]}}, t2_q}
           + SumW'(Half);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      prod0_q <= prod0_d;
      prod1_q <= prod1_d;
      prod2_q <= prod2_d;
      diffl_q <= diffl_d;
      diffg_q <= diffg_d;
      p_q     <= p;
      lo_q    <= entry_i.lower;
      up_q    <= entry_i.upper;
      bp_q    <= bpe;
    end
    if (ctrl_i.s2_en) begin
      t1_q <= t1_d;
      t2_q <= t2_d;
      wv_q <= prod0_q;
      if (ctrl_i.is_init) begin
        res_pos_q <= ip_sum[FW +: DW];
        res_vel_q <= sat32({{(RndW-(P2W-FW)){iv_sum[P2W-1]}}, iv_sum[P2W-1:FW]});
      end
    end
    if (ctrl_i.s3_en) begin
      res_vel_q <= sat32(usum[SumW-1:FW]);
    end
  end

  assign res_o.pos     = p_q;
  assign res_o.lower   = lo_q;
  assign res_o.upper   = up_q;
  assign res_o.best    = bp_q;
  assign res_o.res_pos = res_pos_q;
  assign res_o.res_vel = res_vel_q;

endmodule

FILE: rtl/pso_chk.sv
// port-level checks of the particle update block and their binding
module pso_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [pso_pkg::DataW-1:0]     position_out_o,
  input logic [pso_pkg::DataW-1:0]     velocity_out_o,
  input logic [pso_pkg::DataW-1:0]     best_value_out_o,
  input logic                          improved_o
);

  logic [pso_pkg::DataW-1:0] last_best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_best_q <= pso_pkg::BestValueRst;
    end else if (out_valid_o && !out_stall_i) begin
      last_best_q <= best_value_out_o;
    end
  end

  // one word in flight: the input side closes right after a word is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a word is in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(best_value_out_o)
      && $stable(position_out_o) && $stable(velocity_out_o) && $stable(improved_o)))
    else $error("stalled result changed");

  // personal best value never grows
  a_best_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(best_value_out_o) <= $signed(last_best_q)))
    else $error("personal best value increased");

  // an improvement lowers the best and carries no position or velocity
  a_improved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && improved_o) |-> (($signed(best_value_out_o) < $signed(last_best_q))
      && (position_out_o == '0) && (velocity_out_o == '0)))
    else $error("improved result inconsistent");

endmodule

bind pso_particle_update pso_chk u_pso_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .position_out_o   (position_out_o),
  .velocity_out_o   (velocity_out_o),
  .best_value_out_o (best_value_out_o),
  .improved_o       (improved_o)
);
